/* src/fiuv_pkg.sv */
`timescale 1ns / 1ps
package fiuv_pkg;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        CMD_BEGIN    = 2'd0,
        CMD_WORD     = 2'd1,
        CMD_FINALIZE = 2'd2,
        CMD_ABORT    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_REQ  = 3'd1,
        ST_CRC_BAD  = 3'd2,
        ST_VERIFY   = 3'd3,
        ST_BAD_BEGIN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_SIZE = 2'd0,
        REG_CRC  = 2'd1,
        REG_BASE = 2'd2
    } reg_idx_t;

    // Control between the sequencer and the shared CRC bit unit.
    typedef struct packed {
        logic        load;
        logic [31:0] word;
        logic        step;
    } crc_ctl_t;
endpackage

/* src/fiuv_crc_unit.sv */
`timescale 1ns / 1ps
module fiuv_crc_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fiuv_pkg::crc_ctl_t   ctl,
    input  logic [31:0]          crc_a_in,
    input  logic [31:0]          crc_b_in,
    output logic [31:0]          crc_a,
    output logic [31:0]          crc_b
);
    import fiuv_pkg::*;

    // Two CRC registers advance together, one bit per step, over a shifted word.
    logic [31:0] a_reg, a_next, b_reg, b_next, w_reg, w_next;
    logic        fa, fb;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        w_next = w_reg;
        fa = a_reg[0] ^ w_reg[0];
        fb = b_reg[0] ^ w_reg[0];
        if (ctl.load)
        begin
            a_next = crc_a_in;
            b_next = crc_b_in;
            w_next = ctl.word;
        end
        else if (ctl.step)
        begin
            a_next = (a_reg >> 1) ^ (fa ? CRC_POLY : 32'd0);
            b_next = (b_reg >> 1) ^ (fb ? CRC_POLY : 32'd0);
            w_next = w_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= CRC_ONES;
            b_reg <= 32'd0;
            w_reg <= 32'd0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            w_reg <= w_next;
        end
    end

    assign crc_a = a_reg;
    assign crc_b = b_reg;
endmodule

/* src/flash_image_upload_verifier.sv */
`timescale 1ns / 1ps
// Firmware upload session checker. Commands arrive as input beats: begin,
// chunk word, finalize and abort. Every chunk word that opens a chunk or
// continues an open one is stored in a local buffer, if it lies within the
// buffer depth, and folded into both the chunk CRC and a tentative image
// CRC by one shared bit-serial CRC unit, so the input is not ready while the
// word is stepped through the unit in 32 bit steps. The last word of a chunk
// then goes on to a check state. When that word passes all request and CRC
// checks, the buffer is replayed as one program request per word, each
// staged by a buffer read and then loaded into the output register as long
// as the output takes them; then the replay ends and an ok status beat with
// tlast set is loaded. A failing chunk yields a single status beat, loaded
// after the check. Begin, finalize and abort are accepted and then load a
// status beat, after which the input is ready again.
// The output is a register; a beat waiting in it does not hold off the next
// input beat, only the next output load waits for it. Configuration writes
// are taken at any time but must be made while the block is idle.
module flash_image_upload_verifier #(
    parameter int CHUNK_WORDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: data_word[31:0], chunk_offset[55:32], chunk_length[63:56],
    // chunk_sum[95:64]
    input  logic [95:0] s_tdata,
    // s_tuser: command[1:0], first_word[2]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: program_address[31:0], program_data[63:32], status[66:64], 0
    output logic [71:0] m_tdata,
    // m_tuser: kind[0]
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fiuv_pkg::*;

    localparam int AW = (CHUNK_WORDS > 1) ? $clog2(CHUNK_WORDS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CRC   = 5'b00010,
        S_CHECK = 5'b00100,
        S_PLAY  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [23:0] exp_size_reg;
    logic [31:0] exp_crc_reg, base_reg;
    logic        sess_reg, open_reg, bad_reg, lastw_reg;
    logic [23:0] bytes_reg, offs_reg;
    logic [7:0]  len_reg;
    logic [31:0] run_crc_reg;
    logic [5:0]  cnt_reg, play_reg;
    logic [4:0]  bit_reg;
    logic [31:0] buf_mem [CHUNK_WORDS];
    logic [31:0] rd_reg;
    logic        m_valid_reg, m_kind_reg, m_last_reg;
    logic [31:0] m_addr_reg, m_data_reg;
    logic [2:0]  m_stat_reg;
    logic        pend_reg;
    logic [31:0] pend_addr_reg;
    logic [31:0] s_crc_q;
    logic [2:0]  stat_q;

    logic [1:0]  cmd;
    logic        first;
    logic        acc;
    crc_ctl_t    ctl;
    logic [31:0] crc_a, crc_b;
    logic        out_free;
    logic        emit;
    logic        crc_bad;

    assign cmd   = s_tuser[1:0];
    assign first = s_tuser[2];
    assign acc   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = out_free && (((state_reg == S_PLAY) && pend_reg) || (state_reg == S_OUT));

    // The chunk accumulator restarts at all ones on a first word; the tentative
    // image CRC restarts from the committed running CRC. Otherwise both carry on
    // from where the previous word of the chunk left them.
    always_comb
    begin
        ctl.load = acc && (cmd == CMD_WORD) && (first || open_reg);
        ctl.word = s_tdata[31:0];
        ctl.step = (state_reg == S_CRC);
    end

    fiuv_crc_unit u_crc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .crc_a_in (first ? CRC_ONES : crc_a),
        .crc_b_in (first ? run_crc_reg : crc_b),
        .crc_a    (crc_a),
        .crc_b    (crc_b)
    );

    // Request checks on the closed chunk.
    logic        req_bad;
    logic [24:0] end_pos;
    assign end_pos = {1'b0, offs_reg} + {17'd0, len_reg};
    assign req_bad = !sess_reg || bad_reg || (len_reg == 8'd0) || (offs_reg[1:0] != 2'd0)
                     || (len_reg[1:0] != 2'd0) || ({cnt_reg, 2'b00} != len_reg)
                     || (offs_reg != bytes_reg) || (end_pos > {1'b0, exp_size_reg});
    assign crc_bad = (crc_a ^ CRC_ONES) != s_crc_q;

    always_ff @(posedge clk)
    begin
        if (ctl.load && ((first ? 6'd0 : cnt_reg) < 6'(CHUNK_WORDS)))
        begin
            buf_mem[AW'(first ? 6'd0 : cnt_reg)] <= s_tdata[31:0];
        end
        rd_reg <= buf_mem[AW'(play_reg)];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (acc) state_next = ctl.load ? S_CRC : S_OUT;
            S_CRC:   if (bit_reg == 5'd31) state_next = lastw_reg ? S_CHECK : S_IDLE;
            S_CHECK: state_next = (req_bad || crc_bad) ? S_OUT : S_PLAY;
            S_PLAY:  if (out_free && !pend_reg && play_reg == cnt_reg) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_size_reg  <= 24'd0;
            exp_crc_reg   <= 32'd0;
            base_reg      <= 32'd0;
            sess_reg      <= 1'b0;
            open_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            lastw_reg     <= 1'b0;
            bytes_reg     <= 24'd0;
            offs_reg      <= 24'd0;
            len_reg       <= 8'd0;
            run_crc_reg   <= 32'd0;
            cnt_reg       <= 6'd0;
            play_reg      <= 6'd0;
            bit_reg       <= 5'd0;
            m_valid_reg   <= 1'b0;
            m_kind_reg    <= 1'b0;
            m_last_reg    <= 1'b0;
            m_addr_reg    <= 32'd0;
            m_data_reg    <= 32'd0;
            m_stat_reg    <= ST_OK;
            pend_reg      <= 1'b0;
            pend_addr_reg <= 32'd0;
            stat_q        <= ST_OK;
            s_crc_q       <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE: exp_size_reg <= cfg_data[23:0];
                    REG_CRC:  exp_crc_reg  <= cfg_data;
                    REG_BASE: base_reg     <= cfg_data;
                    default:  ;
                endcase
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        case (cmd)
                            CMD_BEGIN:
                            begin
                                if (exp_crc_reg == CRC_ONES)
                                begin
                                    stat_q <= ST_BAD_BEGIN;
                                end
                                else
                                begin
                                    stat_q      <= ST_OK;
                                    sess_reg    <= 1'b1;
                                    bytes_reg   <= 24'd0;
                                    run_crc_reg <= CRC_ONES;
                                    open_reg    <= 1'b0;
                                    bad_reg     <= 1'b0;
                                    cnt_reg     <= 6'd0;
                                end
                            end
                            CMD_FINALIZE:
                            begin
                                if (!sess_reg || bytes_reg != exp_size_reg
                                    || (run_crc_reg ^ CRC_ONES) != exp_crc_reg)
                                begin
                                    stat_q      <= ST_VERIFY;
                                    bytes_reg   <= 24'd0;
                                    run_crc_reg <= 32'd0;
                                end
                                else
                                begin
                                    stat_q <= ST_OK;
                                end
                                sess_reg <= 1'b0;
                                open_reg <= 1'b0;
                                bad_reg  <= 1'b0;
                                cnt_reg  <= 6'd0;
                            end
                            CMD_ABORT:
                            begin
                                stat_q      <= ST_OK;
                                sess_reg    <= 1'b0;
                                bytes_reg   <= 24'd0;
                                run_crc_reg <= 32'd0;
                                open_reg    <= 1'b0;
                                bad_reg     <= 1'b0;
                                cnt_reg     <= 6'd0;
                            end
                            default:
                            begin
                                if (ctl.load)
                                begin
                                    if (first)
                                    begin
                                        offs_reg <= s_tdata[55:32];
                                        len_reg  <= s_tdata[63:56];
                                    end
                                    // Words past the buffer depth poison the chunk.
                                    if ((first ? 6'd0 : cnt_reg) >= 6'(CHUNK_WORDS))
                                    begin
                                        bad_reg <= 1'b1;
                                    end
                                    else if (first)
                                    begin
                                        bad_reg <= 1'b0;
                                    end
                                    cnt_reg <= first ? 6'd1
                                             : ((cnt_reg < 6'd63) ? cnt_reg + 6'd1 : cnt_reg);
                                    open_reg  <= !s_tlast;
                                    lastw_reg <= s_tlast;
                                    s_crc_q   <= s_tdata[95:64];
                                    bit_reg   <= 5'd0;
                                end
                                else
                                begin
                                    stat_q <= ST_BAD_REQ;
                                end
                            end
                        endcase
                    end
                end
                S_CRC:
                begin
                    bit_reg <= bit_reg + 5'd1;
                end
                S_CHECK:
                begin
                    play_reg <= 6'd0;
                    pend_reg <= 1'b0;
                    if (req_bad)
                    begin
                        stat_q <= ST_BAD_REQ;
                    end
                    else if (crc_bad)
                    begin
                        stat_q <= ST_CRC_BAD;
                    end
                    else
                    begin
                        stat_q      <= ST_OK;
                        run_crc_reg <= crc_b;
                        bytes_reg   <= bytes_reg + {16'd0, len_reg};
                    end
                    if (req_bad || crc_bad)
                    begin
                        cnt_reg <= 6'd0;
                        bad_reg <= 1'b0;
                    end
                end
                S_PLAY:
                begin
                    // rd_reg picks up the entry at play_reg on the same edge that
                    // moves the index on, so a beat is staged behind a pending flag
                    // and loaded into the output once the output register is free.
                    if (out_free)
                    begin
                        if (pend_reg)
                        begin
                            m_kind_reg <= 1'b1;
                            m_last_reg <= 1'b0;
                            m_addr_reg <= pend_addr_reg;
                            m_data_reg <= rd_reg;
                            m_stat_reg <= ST_OK;
                            pend_reg   <= 1'b0;
                        end
                        else if (play_reg != cnt_reg)
                        begin
                            pend_reg      <= 1'b1;
                            pend_addr_reg <= base_reg + {8'd0, offs_reg}
                                             + {24'd0, play_reg, 2'b00};
                            play_reg      <= play_reg + 6'd1;
                        end
                        else
                        begin
                            cnt_reg <= 6'd0;
                            bad_reg <= 1'b0;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_kind_reg <= 1'b0;
                        m_last_reg <= 1'b1;
                        m_addr_reg <= 32'd0;
                        m_data_reg <= 32'd0;
                        m_stat_reg <= stat_q;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_stat_reg, m_data_reg, m_addr_reg};
endmodule

/* src/fiuv_checker.sv */
`timescale 1ns / 1ps
module fiuv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast,
    input logic        m_tuser,
    input logic [71:0] m_tdata
);
    // A program request never carries the final flag.
    a_req_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("program request marked last");

    // A status beat is always last.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status beat not last");

    // Once an input beat is taken the block is not ready in the cycle after it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled output changed");
endmodule

bind flash_image_upload_verifier fiuv_checker u_fiuv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
